// ===== src/asrf_pkg.sv =====
// Shared types and constants for the audio sample ring FIFO.
package asrf_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned LenW = 11;
  localparam int unsigned DropW = 32;
  localparam int unsigned LogW = 4;
  localparam logic [LogW-1:0] LogMin = 4'd4;
  localparam logic [LogW-1:0] LogMax = 4'd10;
  localparam logic [LogW-1:0] LogReset = 4'd10;

  typedef enum logic [1:0] {
    OP_BEGIN = 2'd0,
    OP_PUSH  = 2'd1,
    OP_PULL  = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]                operation;
    logic [LenW-1:0]           buffer_length;
    logic signed [SampleW-1:0] sample_in;
  } in_item_t;

  typedef struct packed {
    logic signed [SampleW-1:0] sample_out;
    logic                      underrun;
    logic                      buffer_accepted;
    logic [DropW-1:0]          dropped_buffers;
    logic [LenW-1:0]           fill_level;
  } out_item_t;

  typedef struct packed {
    logic             use_rdata;
    logic             underrun;
    logic             buffer_accepted;
    logic [DropW-1:0] dropped_buffers;
    logic [LenW-1:0]  fill_level;
  } resp_meta_t;

endpackage

// ===== src/asrf_mem.sv =====
// Sample store: single write port, single read port, registered read data.
module asrf_mem
  import asrf_pkg::*;
#(
  parameter int unsigned AW = 10
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [AW-1:0]      waddr_i,
  input  logic [SampleW-1:0] wdata_i,
  input  logic               re_i,
  input  logic [AW-1:0]      raddr_i,
  output logic [SampleW-1:0] rdata_o
);

  logic [SampleW-1:0] mem [2**AW];
  logic [SampleW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/asrf_ctrl.sv =====
// Ring pointer control: begin, push and pull handling, drop counter and size register.
module asrf_ctrl
  import asrf_pkg::*;
#(
  parameter int unsigned AW = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [LogW-1:0]    cfg_data_i,
  input  logic               accept_i,
  input  in_item_t           item_i,
  output logic               we_o,
  output logic [AW-1:0]      waddr_o,
  output logic [SampleW-1:0] wdata_o,
  output logic               re_o,
  output logic [AW-1:0]      raddr_o,
  output resp_meta_t         meta_o
);

  localparam int unsigned CW = AW + 1;
  localparam int unsigned LW = (CW > LenW) ? CW : LenW;
  localparam logic [LogW-1:0] LogDepth = (AW >= int'(LogMax)) ? LogMax : LogW'(AW);

  logic [LogW-1:0]  log_q;
  logic [CW-1:0]    rd_q, rd_d;
  logic [CW-1:0]    pub_q, pub_d;
  logic [CW-1:0]    stg_q, stg_d;
  logic [LenW-1:0]  left_q, left_d;
  logic             open_q, open_d;
  logic [DropW-1:0] drop_q, drop_d;

  logic [LogW-1:0] log_c;
  logic [LogW-1:0] log_e;
  logic [AW-1:0]   addr_mask;
  logic [CW-1:0]   cap;
  logic [CW-1:0]   used;
  logic [CW-1:0]   free_space;
  logic [CW-1:0]   used_next;
  logic [LW-1:0]   used_next_w;
  logic [LenW-1:0] left_dec;
  logic            under;
  logic            acc;

  always_comb begin
    if (log_q < LogMin) begin
      log_c = LogMin;
    end else if (log_q > LogMax) begin
      log_c = LogMax;
    end else begin
      log_c = log_q;
    end
    log_e = (log_c > LogDepth) ? LogDepth : log_c;
  end

  assign addr_mask  = AW'(~({CW{1'b1}} << log_e));
  assign cap        = CW'(1) << log_e;
  assign used       = pub_q - rd_q;
  assign free_space = (used >= cap) ? '0 : (cap - used);
  assign left_dec   = left_q - LenW'(1);

  always_comb begin
    rd_d    = rd_q;
    pub_d   = pub_q;
    stg_d   = stg_q;
    left_d  = left_q;
    open_d  = open_q;
    drop_d  = drop_q;
    we_o    = 1'b0;
    re_o    = 1'b0;
    under   = 1'b0;
    acc     = 1'b0;
    waddr_o = stg_q[AW-1:0] & addr_mask;
    raddr_o = rd_q[AW-1:0] & addr_mask;
    wdata_o = item_i.sample_in;
    if (cfg_we_i) begin
      rd_d   = '0;
      pub_d  = '0;
      stg_d  = '0;
      left_d = '0;
      open_d = 1'b0;
    end else if (accept_i) begin
      case (op_e'(item_i.operation))
        OP_BEGIN: begin
          stg_d  = pub_q;
          open_d = 1'b0;
          left_d = '0;
          if (LW'(item_i.buffer_length) > LW'(free_space)) begin
            if (drop_q != '1) begin
              drop_d = drop_q + DropW'(1);
            end
          end else begin
            acc = 1'b1;
            if (item_i.buffer_length != '0) begin
              left_d = item_i.buffer_length;
              open_d = 1'b1;
            end
          end
        end
        OP_PUSH: begin
          if (open_q) begin
            we_o   = 1'b1;
            stg_d  = stg_q + CW'(1);
            left_d = left_dec;
            if (left_dec == '0) begin
              pub_d  = stg_q + CW'(1);
              open_d = 1'b0;
            end
          end
        end
        OP_PULL: begin
          if (used == '0) begin
            under = 1'b1;
          end else begin
            re_o = 1'b1;
            rd_d = rd_q + CW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign used_next   = pub_d - rd_d;
  assign used_next_w = LW'(used_next);

  always_comb begin
    meta_o.use_rdata       = re_o;
    meta_o.underrun        = under;
    meta_o.buffer_accepted = acc;
    meta_o.dropped_buffers = drop_d;
    meta_o.fill_level      = used_next_w[LenW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log_q  <= LogReset;
      rd_q   <= '0;
      pub_q  <= '0;
      stg_q  <= '0;
      left_q <= '0;
      open_q <= 1'b0;
      drop_q <= '0;
    end else begin
      if (cfg_we_i) begin
        log_q <= cfg_data_i;
      end
      rd_q   <= rd_d;
      pub_q  <= pub_d;
      stg_q  <= stg_d;
      left_q <= left_d;
      open_q <= open_d;
      drop_q <= drop_d;
    end
  end

endmodule

// ===== src/asrf_out.sv =====
// Response stage: stays pending for read data, then holds the result for the receiver.
module asrf_out
  import asrf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  resp_meta_t         meta_i,
  input  logic [SampleW-1:0] rdata_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_item_t          out_item_o
);

  logic       pend_q, pend_d;
  resp_meta_t meta_q;
  logic       out_valid_q, out_valid_d;
  out_item_t  out_item_q;
  logic       advance;

  assign advance    = pend_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !pend_q || advance;

  always_comb begin
    pend_d = pend_q;
    if (accept_i) begin
      pend_d = 1'b1;
    end else if (advance) begin
      pend_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      meta_q <= meta_i;
    end
    if (advance) begin
      out_item_q.sample_out      <= meta_q.use_rdata ? rdata_i : '0;
      out_item_q.underrun        <= meta_q.underrun;
      out_item_q.buffer_accepted <= meta_q.buffer_accepted;
      out_item_q.dropped_buffers <= meta_q.dropped_buffers;
      out_item_q.fill_level      <= meta_q.fill_level;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== src/audio_sample_ring_fifo.sv =====
// Top level of the audio sample ring FIFO with staged buffer publishing.
//
// Input transfers carry one operation: begin a buffer of a given length, push one
// sample of the open buffer, pull one published sample, or a status-only no-op.
// Every input transfer yields exactly one output transfer with the pulled sample,
// underrun and acceptance flags, the saturating drop count and the fill level.
// A begin whose length exceeds the free space is dropped and counted; pushed
// samples become readable only when the last sample of their buffer arrives.
// The accepting edge updates the pointers, starts the sample memory read and fills
// the pending stage; the result register then loads from it and raises output valid
// once the output register is free or being drained.
// Throughput is one item per cycle while the receiver keeps ready high; the single
// read port of the sample memory and the one pending stage set this figure.
// When the receiver stalls, one result waits in the output register and one more
// in the pending stage; input ready then drops until the output drains.
// The configuration channel writes the ring size log2 and flushes all pointers;
// the drop count is kept. Reset empties the FIFO, clears the drop count and sets
// the ring size log2 to ten. Memory contents are not cleared.
module audio_sample_ring_fifo
  import asrf_pkg::*;
#(
  parameter int unsigned RING_DEPTH = 1024
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [LogW-1:0] cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  in_item_t        in_item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output out_item_t       out_item_o
);

  localparam int unsigned AW = $clog2(RING_DEPTH);

  logic               cfg_we;
  logic               in_accept;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [SampleW-1:0] wdata;
  logic               re;
  logic [AW-1:0]      raddr;
  logic [SampleW-1:0] rdata;
  resp_meta_t         meta;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign in_accept   = in_valid_i && in_ready_o;

  asrf_ctrl #(
    .AW(AW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data_i),
    .accept_i   (in_accept),
    .item_i     (in_item_i),
    .we_o       (we),
    .waddr_o    (waddr),
    .wdata_o    (wdata),
    .re_o       (re),
    .raddr_o    (raddr),
    .meta_o     (meta)
  );

  asrf_mem #(
    .AW(AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  asrf_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .meta_i      (meta),
    .rdata_i     (rdata),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== bench/audio_sample_ring_fifo_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the audio sample ring FIFO with a built-in ring predictor.
module audio_sample_ring_fifo_test;
  import asrf_pkg::*;

  localparam int unsigned RingDepth = 1024;
  localparam int unsigned StallLimit = 4000;

  class ring_fifo_scoreboard;
    logic [SampleW-1:0] ring_mem [RingDepth];
    logic [LenW-1:0]    rd_cnt;
    logic [LenW-1:0]    pub_cnt;
    logic [LenW-1:0]    stg_cnt;
    logic [LenW-1:0]    left_cnt;
    logic               buf_open;
    logic [DropW-1:0]   drop_cnt;
    logic [LogW-1:0]    size_log2;
    out_item_t          due_status[$];
    int                 errors;

    function new();
      size_log2 = LogReset;
      drop_cnt = '0;
      errors = 0;
      flush();
    endfunction

    function void flush();
      rd_cnt = '0;
      pub_cnt = '0;
      stg_cnt = '0;
      left_cnt = '0;
      buf_open = 1'b0;
    endfunction

    function int unsigned capacity();
      int unsigned lg;
      lg = size_log2;
      if (lg < LogMin) lg = LogMin;
      if (lg > LogMax) lg = LogMax;
      return 1 << lg;
    endfunction

    function logic [LenW-1:0] fill();
      return pub_cnt - rd_cnt;
    endfunction

    function void write_ring_log2(logic [LogW-1:0] value);
      size_log2 = value;
      flush();
    endfunction

    function void take_item(in_item_t item);
      out_item_t       res;
      int unsigned     cap;
      int unsigned     used;
      int unsigned     room;
      logic [LenW-1:0] mask;
      res = '0;
      cap = capacity();
      mask = LenW'(cap - 1);
      case (op_e'(item.operation))
        OP_BEGIN: begin
          used = fill();
          room = (used >= cap) ? 0 : cap - used;
          stg_cnt = pub_cnt;
          buf_open = 1'b0;
          left_cnt = '0;
          if (item.buffer_length > room) begin
            if (drop_cnt != '1) drop_cnt++;
          end else begin
            res.buffer_accepted = 1'b1;
            if (item.buffer_length != 0) begin
              left_cnt = item.buffer_length;
              buf_open = 1'b1;
            end
          end
        end
        OP_PUSH: begin
          if (buf_open) begin
            ring_mem[stg_cnt & mask] = item.sample_in;
            stg_cnt++;
            left_cnt--;
            if (left_cnt == 0) begin
              pub_cnt = stg_cnt;
              buf_open = 1'b0;
            end
          end
        end
        OP_PULL: begin
          if (fill() == 0) begin
            res.underrun = 1'b1;
          end else begin
            res.sample_out = ring_mem[rd_cnt & mask];
            rd_cnt++;
          end
        end
        default: ;
      endcase
      res.dropped_buffers = drop_cnt;
      res.fill_level = fill();
      due_status.push_back(res);
    endfunction

    function void compare_field(string field, longint want, longint got);
      if (want != got) begin
        errors++;
        $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (due_status.size() == 0) begin
        errors++;
        $display("%0t: result expected none, actual sample_out %0d fill_level %0d",
                 $time, got.sample_out, got.fill_level);
        return;
      end
      want = due_status.pop_front();
      compare_field("sample_out", want.sample_out, got.sample_out);
      compare_field("underrun", want.underrun, got.underrun);
      compare_field("buffer_accepted", want.buffer_accepted, got.buffer_accepted);
      compare_field("dropped_buffers", want.dropped_buffers, got.dropped_buffers);
      compare_field("fill_level", want.fill_level, got.fill_level);
    endfunction
  endclass

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_valid_i;
  logic            cfg_ready_o;
  logic [LogW-1:0] cfg_data_i;
  logic            in_valid_i;
  logic            in_ready_o;
  in_item_t        in_item_i;
  logic            out_valid_o;
  logic            out_ready_i;
  out_item_t       out_item_o;

  ring_fifo_scoreboard fifo_sb;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned src_gap_pct;
  int unsigned sink_stall_pct;
  bit          calm_tail;

  audio_sample_ring_fifo dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [SampleW-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      default: return SampleW'($urandom);
    endcase
  endfunction

  task automatic offer(input op_e op, input logic [LenW-1:0] len,
                       input logic [SampleW-1:0] smp);
    in_item_t item;
    int unsigned gap;
    if ($urandom_range(0, 99) < src_gap_pct) begin
      gap = $urandom_range(1, 8);
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    item.operation = op;
    item.buffer_length = len;
    item.sample_in = smp;
    @(negedge clk_i);
    in_valid_i = 1'b1;
    in_item_i = item;
    do @(posedge clk_i); while (!in_ready_o);
    fifo_sb.take_item(item);
    items_sent++;
  endtask

  task automatic wait_for_results();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (fifo_sb.due_status.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_ring_log2(input logic [LogW-1:0] value);
    wait_for_results();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    fifo_sb.write_ring_log2(value);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic run_phase(input int unsigned n_items, input bit mid_drain);
    int unsigned start;
    int unsigned cap;
    int unsigned room;
    int unsigned len;
    int unsigned n_push;
    int unsigned pick;
    start = items_sent;
    while (items_sent - start < n_items) begin
      if (mid_drain && items_sent - start >= n_items / 2) begin
        mid_drain = 1'b0;
        wait_for_results();
      end
      if (!calm_tail) begin
        if ($urandom_range(0, 7) == 0) begin
          src_gap_pct = 0;
          sink_stall_pct = 0;
        end else if ($urandom_range(0, 3) == 0) begin
          src_gap_pct = 20;
          sink_stall_pct = 20;
        end
      end
      cap = fifo_sb.capacity();
      room = cap - fifo_sb.fill();
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        case ($urandom_range(0, 9))
          0: len = room + $urandom_range(1, 4);
          1: len = (room <= 64) ? room : $urandom_range(1, 32);
          default: len = $urandom_range(1, (cap <= 64) ? cap : 32);
        endcase
        offer(OP_BEGIN, LenW'(len), rand_sample());
        n_push = fifo_sb.buf_open ? len : 0;
        for (int i = 0; i < n_push; i++) begin
          if ($urandom_range(0, 99) < 30) offer(OP_PULL, LenW'($urandom), rand_sample());
          offer(OP_PUSH, LenW'($urandom), rand_sample());
        end
        repeat ($urandom_range(0, n_push)) offer(OP_PULL, LenW'($urandom), rand_sample());
      end else if (pick < 75) begin
        repeat ($urandom_range(1, 16)) offer(OP_PULL, LenW'($urandom), rand_sample());
      end else if (pick < 85) begin
        len = $urandom_range(2, 12);
        offer(OP_BEGIN, LenW'(len), rand_sample());
        repeat ($urandom_range(0, len - 1)) offer(OP_PUSH, LenW'($urandom), rand_sample());
      end else begin
        offer(op_e'($urandom_range(0, 3)), LenW'($urandom), rand_sample());
      end
    end
  endtask

  initial begin
    int unsigned stall_left;
    bit          long_hold_done;
    stall_left = 0;
    long_hold_done = 1'b0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        fifo_sb.check_result(out_item_o);
        results_seen++;
      end
      @(negedge clk_i);
      if (stall_left != 0) begin
        stall_left--;
        out_ready_i = 1'b0;
      end else if (!long_hold_done && results_seen >= 350) begin
        long_hold_done = 1'b1;
        stall_left = 79;
        out_ready_i = 1'b0;
      end else if ($urandom_range(0, 99) < sink_stall_pct) begin
        stall_left = $urandom_range(0, 7);
        out_ready_i = 1'b0;
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("audio_sample_ring_fifo: mismatch");
        $finish;
      end
    end
  end

  initial begin
    fifo_sb = new();
    items_sent = 0;
    results_seen = 0;
    src_gap_pct = 20;
    sink_stall_pct = 20;
    calm_tail = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = LogReset;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    offer(OP_PULL, '0, '0);
    offer(OP_NOP, 11'h7ff, 16'hffff);
    offer(OP_PUSH, '0, 16'h7fff);
    offer(OP_BEGIN, 11'd0, '0);
    offer(OP_BEGIN, 11'd1025, '0);
    offer(OP_BEGIN, 11'h7ff, '0);
    offer(OP_BEGIN, 11'd3, '0);
    offer(OP_PUSH, '0, 16'h8000);
    offer(OP_PUSH, '0, 16'h7fff);
    offer(OP_BEGIN, 11'd2, '0);
    offer(OP_PUSH, '0, 16'h5555);
    offer(OP_PUSH, 11'h7ff, 16'haaaa);
    offer(OP_PULL, '0, '0);
    offer(OP_PULL, '0, '0);
    offer(OP_PULL, '0, '0);
    offer(OP_BEGIN, 11'd1, '0);
    offer(OP_PUSH, '0, 16'hffff);
    offer(OP_NOP, 11'h555, 16'h1234);
    offer(OP_PULL, 11'h2aa, 16'hedcb);

    write_ring_log2(4'd4);
    run_phase(220, 1'b0);
    write_ring_log2(4'd7);
    run_phase(200, 1'b1);
    write_ring_log2(4'd15);
    run_phase(150, 1'b0);
    write_ring_log2(4'd0);
    run_phase(150, 1'b0);
    write_ring_log2(4'd11);
    run_phase(100, 1'b0);
    write_ring_log2(4'd10);
    calm_tail = 1'b1;
    src_gap_pct = 0;
    sink_stall_pct = 0;
    run_phase(250, 1'b0);

    wait_for_results();
    repeat (8) @(posedge clk_i);
    if (fifo_sb.errors == 0 && fifo_sb.due_status.size() == 0) begin
      $display("audio_sample_ring_fifo: match");
    end else begin
      $display("audio_sample_ring_fifo: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/asrf_pkg.sv
src/asrf_mem.sv
src/asrf_ctrl.sv
src/asrf_out.sv
src/audio_sample_ring_fifo.sv
bench/audio_sample_ring_fifo_test.sv
